// ===== src/epsm_pkg.sv =====
package epsm_pkg;

	localparam int POS_W      = 32;
	localparam int TIME_W     = 32;
	localparam int SPEED_W    = 16;
	localparam int SHSPD_W    = 26;
	localparam int REVS_W     = 42;
	localparam int CP_W       = 8;
	localparam int MAXSPD_W   = 15;
	localparam int TMO_W      = 16;
	localparam int CPR_W      = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam int US_PER_S   = 1000000;
	localparam int MILLI      = 1000;

	// edge period * 1e6 fits 28 bits, |position| * 1000 fits 41, |speed| * 1000 fits 25
	localparam int PER_PROD_W = 28;
	localparam int POS_PROD_W = 41;
	localparam int SP_PROD_W  = 25;

	// us to ms: floor(x / 1000) == (x * ceil(2^38 / 1000)) >> 38 for any 32-bit x
	localparam int MS_RECIP   = 274877907;
	localparam int MS_SHIFT   = 38;
	localparam int MS_PROD_W  = 61;

	localparam logic [CFG_IDX_W-1:0] REG_EDGE_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_CEIL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REV_COUNTS  = 2'd3;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_CHECK  = 1'b1;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_UPDATE = 2'd1,
		KIND_CHECK  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [CP_W-1:0]     edge_period;
		logic [MAXSPD_W-1:0] speed_ceil;
		logic [TMO_W-1:0]    timeout_ms;
		logic [CPR_W-1:0]    rev_counts;
	} cfg_t;

	// arg: elapsed microseconds for an update, last update time for a check
	typedef struct packed {
		kind_t               kind;
		logic                fwd;
		logic [POS_W-1:0]    position;
		logic [TIME_W-1:0]   arg;
		logic [TIME_W-1:0]   time_ms;
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]    position;
		logic [SPEED_W-1:0]  counts_per_second;
		logic [SHSPD_W-1:0]  shaft_speed_milli;
		logic [REVS_W-1:0]   shaft_revs_milli;
		logic                speed_updated;
	} res_t;

endpackage

// ===== src/encoder_position_speed_meter_core.sv =====
// Datapath: every item passes the position divider and the shaft-speed division; an update
// with elapsed time first divides for its speed, so it takes longer than other items.
// The datapath handles one item at a time, paced by the 32-step shared speed
// divider (used twice for dividing updates) and the 41-step position divider.
// Up to QUEUE_DEPTH items are buffered between the input side and the datapath.
// Reset: arst_n asynchronously restores the register defaults and clears the control state.
module encoder_position_speed_meter_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic         s_tuser,    // func
	input  logic [71:0]  s_tdata,    // pin_a, pin_b, time_us, time_ms, zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic         m_tuser,    // speed_updated
	output logic [119:0] m_tdata     // position, counts_per_second, shaft_speed_milli,
	                                 // shaft_revs_milli, zero pad
);

	epsm_pkg::cfg_t cfg_q;
	epsm_pkg::cmd_t push_cmd;
	epsm_pkg::cmd_t pop_cmd;
	epsm_pkg::res_t res;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_period <= 8'd6;
			cfg_q.speed_ceil  <= 15'd10000;
			cfg_q.timeout_ms  <= 16'd300;
			cfg_q.rev_counts  <= 16'd390;
		end else if (cfg_we) begin
			unique case (cfg_index)
				epsm_pkg::REG_EDGE_PERIOD: cfg_q.edge_period <= cfg_wdata[7:0];
				epsm_pkg::REG_SPEED_CEIL:  cfg_q.speed_ceil  <= cfg_wdata[14:0];
				epsm_pkg::REG_TIMEOUT_MS:  cfg_q.timeout_ms  <= cfg_wdata;
				epsm_pkg::REG_REV_COUNTS:  cfg_q.rev_counts  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	epsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	epsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.rd_cmd (pop_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	epsm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_cmd    (pop_cmd),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tuser = res.speed_updated;
	assign m_tdata = {4'd0, res.shaft_revs_milli, res.shaft_speed_milli,
	                  res.counts_per_second, res.position};

endmodule

// ===== src/epsm_front.sv =====
module epsm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  epsm_pkg::cfg_t       cfg,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 s_tuser,   // func
	input  logic [71:0]          s_tdata,   // pin_a, pin_b, time_us, time_ms
	input  logic                 q_full,
	output logic                 push,
	output epsm_pkg::cmd_t       cmd
);

	logic                          a_was_high_q;
	logic [epsm_pkg::CP_W-1:0]     tally_q;
	logic [epsm_pkg::POS_W-1:0]    position_q;
	logic [epsm_pkg::TIME_W-1:0]   last_us_q;

	logic                          pin_a;
	logic                          pin_b;
	logic [epsm_pkg::TIME_W-1:0]   t_us;
	logic [epsm_pkg::TIME_W-1:0]   t_ms;
	logic                          is_check;
	logic                          rise;
	logic                          upd;
	logic [epsm_pkg::CP_W-1:0]     tally_nx;
	logic [epsm_pkg::POS_W-1:0]    pos_nx;

	assign pin_a    = s_tdata[0];
	assign pin_b    = s_tdata[1];
	assign t_us     = s_tdata[33:2];
	assign t_ms     = s_tdata[65:34];
	assign is_check = (s_tuser == epsm_pkg::FUNC_CHECK);

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	assign rise     = !is_check && !a_was_high_q && pin_a;
	assign tally_nx = tally_q + 1'b1;
	assign pos_nx   = pin_b ? position_q - 1'b1 : position_q + 1'b1;
	assign upd      = rise && (tally_nx == cfg.edge_period);

	always_comb begin
		cmd.kind     = is_check ? epsm_pkg::KIND_CHECK
		             : (upd ? epsm_pkg::KIND_UPDATE : epsm_pkg::KIND_SAMPLE);
		cmd.fwd      = !pin_b;
		cmd.position = rise ? pos_nx : position_q;
		cmd.arg      = is_check ? last_us_q : t_us - last_us_q;
		cmd.time_ms  = t_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_was_high_q <= 1'b0;
			tally_q      <= '0;
			position_q   <= '0;
			last_us_q    <= '0;
		end else if (push && !is_check) begin
			if (!a_was_high_q) begin
				if (pin_a) begin
					a_was_high_q <= 1'b1;
					position_q   <= pos_nx;
					tally_q      <= upd ? '0 : tally_nx;
					if (upd) begin
						last_us_q <= t_us;
					end
				end
			end else if (!pin_a) begin
				a_was_high_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/epsm_queue.sv =====
module epsm_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  epsm_pkg::cmd_t  wr_cmd,
	input  logic            pop,
	output epsm_pkg::cmd_t  rd_cmd,
	output logic            full,
	output logic            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	epsm_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/epsm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module epsm_div #(
	parameter int NW = 32,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          ge;

	assign shifted  = {rem_q, quo_q[NW-1]};
	assign ge       = (shifted >= {1'b0, dvs_q});
	assign diff     = shifted - {1'b0, dvs_q};
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/epsm_back.sv =====
module epsm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  epsm_pkg::cfg_t  cfg,
	input  logic            q_empty,
	input  epsm_pkg::cmd_t  q_cmd,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output epsm_pkg::res_t  res
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_PREP    = 8'b0000_0010,
		ST_START   = 8'b0000_0100,
		ST_SPD     = 8'b0000_1000,
		ST_SHPREP  = 8'b0001_0000,
		ST_SHSTART = 8'b0010_0000,
		ST_SHWAIT  = 8'b0100_0000,
		ST_FIN     = 8'b1000_0000
	} state_t;

	state_t                             state_q;
	epsm_pkg::cmd_t                     cmd_q;
	logic [epsm_pkg::SPEED_W-1:0]       speed_q;
	logic [epsm_pkg::PER_PROD_W-1:0]    per_prod_q;
	logic [epsm_pkg::POS_PROD_W-1:0]    pos_prod_q;
	logic [epsm_pkg::SP_PROD_W-1:0]     sp_prod_q;
	logic [epsm_pkg::TIME_W-1:0]        lastms_q;
	logic                               m_tvalid_q;
	epsm_pkg::res_t                     res_q;

	logic [epsm_pkg::POS_W-1:0]         pos_abs;
	logic [epsm_pkg::MAXSPD_W-1:0]      sp_abs;
	logic [epsm_pkg::MAXSPD_W-1:0]      mag;
	logic [epsm_pkg::MS_PROD_W-1:0]     ms_prod;
	logic [epsm_pkg::TIME_W-1:0]        since;
	logic                               out_free;
	logic                               spd_div;

	logic                               a_busy;
	logic [epsm_pkg::POS_PROD_W-1:0]    a_quo;
	logic                               b_start;
	logic [epsm_pkg::TIME_W-1:0]        b_dividend;
	logic [epsm_pkg::TIME_W-1:0]        b_divisor;
	logic                               b_busy;
	logic [epsm_pkg::TIME_W-1:0]        b_quo;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign res      = res_q;

	assign pos_abs = cmd_q.position[epsm_pkg::POS_W-1] ? -cmd_q.position : cmd_q.position;
	assign sp_abs  = speed_q[epsm_pkg::SPEED_W-1] ? epsm_pkg::MAXSPD_W'(-speed_q)
	                                               : speed_q[epsm_pkg::MAXSPD_W-1:0];
	assign mag     = (b_quo > epsm_pkg::TIME_W'(cfg.speed_ceil)) ? cfg.speed_ceil
	                                                             : b_quo[epsm_pkg::MAXSPD_W-1:0];
	assign ms_prod = epsm_pkg::MS_PROD_W'(cmd_q.arg)
	               * epsm_pkg::MS_PROD_W'(epsm_pkg::MS_RECIP);
	assign since   = cmd_q.time_ms - lastms_q;
	assign spd_div = (cmd_q.kind == epsm_pkg::KIND_UPDATE) && (cmd_q.arg != '0);

	// divider b is shared: speed period, then shaft speed
	always_comb begin
		b_start    = 1'b0;
		b_dividend = epsm_pkg::TIME_W'(sp_prod_q);
		b_divisor  = epsm_pkg::TIME_W'(cfg.rev_counts);
		if (state_q == ST_START && spd_div) begin
			b_start    = 1'b1;
			b_dividend = epsm_pkg::TIME_W'(per_prod_q);
			b_divisor  = cmd_q.arg;
		end else if (state_q == ST_SHSTART) begin
			b_start = 1'b1;
		end
	end

	epsm_div #(
		.NW (epsm_pkg::POS_PROD_W),
		.DW (epsm_pkg::CPR_W)
	) u_div_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_START),
		.dividend (pos_prod_q),
		.divisor  (cfg.rev_counts),
		.busy     (a_busy),
		.quotient (a_quo)
	);

	epsm_div #(
		.NW (epsm_pkg::TIME_W),
		.DW (epsm_pkg::TIME_W)
	) u_div_spd (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (b_start),
		.dividend (b_dividend),
		.divisor  (b_divisor),
		.busy     (b_busy),
		.quotient (b_quo)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_PREP) begin
			pos_prod_q <= epsm_pkg::POS_PROD_W'(pos_abs)
			            * epsm_pkg::POS_PROD_W'(epsm_pkg::MILLI);
			per_prod_q <= epsm_pkg::PER_PROD_W'(cfg.edge_period)
			            * epsm_pkg::PER_PROD_W'(epsm_pkg::US_PER_S);
			lastms_q   <= epsm_pkg::TIME_W'(ms_prod[epsm_pkg::MS_PROD_W-1:epsm_pkg::MS_SHIFT]);
		end
		if (state_q == ST_SHPREP) begin
			sp_prod_q <= epsm_pkg::SP_PROD_W'(sp_abs) * epsm_pkg::SP_PROD_W'(epsm_pkg::MILLI);
		end
		if (state_q == ST_FIN && out_free) begin
			res_q.position          <= cmd_q.position;
			res_q.counts_per_second <= speed_q;
			res_q.speed_updated     <= (cmd_q.kind == epsm_pkg::KIND_UPDATE);
			if (cfg.rev_counts == '0) begin
				res_q.shaft_speed_milli <= '0;
				res_q.shaft_revs_milli  <= '0;
			end else begin
				res_q.shaft_speed_milli <= speed_q[epsm_pkg::SPEED_W-1]
				    ? -epsm_pkg::SHSPD_W'(b_quo[epsm_pkg::SP_PROD_W-1:0])
				    :  epsm_pkg::SHSPD_W'(b_quo[epsm_pkg::SP_PROD_W-1:0]);
				res_q.shaft_revs_milli  <= cmd_q.position[epsm_pkg::POS_W-1]
				    ? -epsm_pkg::REVS_W'(a_quo)
				    :  epsm_pkg::REVS_W'(a_quo);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			speed_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_START;
				end
				ST_START: begin
					if (spd_div) begin
						state_q <= ST_SPD;
					end else begin
						// update with no elapsed time: full-scale speed
						if (cmd_q.kind == epsm_pkg::KIND_UPDATE) begin
							speed_q <= cmd_q.fwd ? {1'b0, cfg.speed_ceil}
							                     : -{1'b0, cfg.speed_ceil};
						end else if (cmd_q.kind == epsm_pkg::KIND_CHECK
						             && since > epsm_pkg::TIME_W'(cfg.timeout_ms)) begin
							speed_q <= '0;
						end
						state_q <= ST_SHPREP;
					end
				end
				ST_SPD: begin
					if (!b_busy) begin
						speed_q <= cmd_q.fwd ? {1'b0, mag} : -{1'b0, mag};
						state_q <= ST_SHPREP;
					end
				end
				ST_SHPREP: begin
					state_q <= ST_SHSTART;
				end
				ST_SHSTART: begin
					state_q <= ST_SHWAIT;
				end
				ST_SHWAIT: begin
					if (!b_busy && !a_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/epsm_checker.sv =====
module epsm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic         m_tuser,
	input logic [119:0] m_tdata
);

	// a stalled result transfer holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// speed saturates symmetrically, never the most negative code
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:32] != 16'h8000)
		else $error("speed outside symmetric range");

	a_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[47:32] == 16'h0000 |-> m_tdata[73:48] == 26'd0)
		else $error("shaft speed nonzero at zero speed");

	a_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:0] == 32'd0 |-> m_tdata[115:74] == 42'd0)
		else $error("shaft revolutions nonzero at zero position");

endmodule

bind encoder_position_speed_meter_core epsm_checker u_epsm_checker (.*);
